/* design/hrde_pkg.sv */
// ----------------------------------------------------------------------------
// hrde_pkg
// Shared types, constants and the character decoder for the hex record data
// extractor.
// ----------------------------------------------------------------------------
package hrde_pkg;

    localparam logic [31:0] BASE_RESET  = 32'h0800_0000;
    localparam logic [7:0]  CHAR_COLON  = 8'd58;
    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_NINE   = 8'd57;
    localparam logic [7:0]  ALPHA_BIAS  = 8'd55;

    // Record layout: character positions after the colon
    localparam logic [9:0]  POS_COUNT_END  = 10'd2;
    localparam logic [9:0]  POS_OFFSET_END = 10'd6;
    localparam logic [9:0]  POS_SKIP       = 10'd7;
    localparam logic [9:0]  POS_TYPE       = 10'd8;
    localparam logic [9:0]  POS_DATA       = 10'd9;

    localparam logic [3:0]  TYPE_DATA = 4'd0;

    // One output halfword with its address, index and end-of-record flag
    typedef struct packed {
        logic [31:0] record_address;
        logic [6:0]  word_index;
        logic [15:0] halfword;
        logic        last;
    } result_t;

    // Digits map to 0..9, everything else is offset by 55, low 4 bits kept
    function automatic logic [3:0] to_nibble(input logic [7:0] c);
        logic [7:0] diff;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                diff = c - CHAR_ZERO;
            else
                diff = c - ALPHA_BIAS;
            return diff[3:0];
        end
    endfunction

endpackage

/* design/hex_record_data_extractor.sv */
// ----------------------------------------------------------------------------
// hex_record_data_extractor
// Parses Intel HEX character streams and emits the data bytes of each data
// record as little-endian halfwords tagged with address and index.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata / payload                                | tuser/tlast
//  s_axis   | in  | [7:0] char_in                                  | -
//  m_axis   | out | [31:0] record_address, [38:32] word_index,     | tlast = last
//           |     | [54:39] halfword, [55] zero                    |
//  cfg      | in  | [31:0] base_address                            | -
//
//  One character per cycle sustained while m_axis accepts results; a result
//  is offered on m_axis once its character has passed the input register and
//  the result has been caught in the output register (input register, then output register).
//  The parser step is the only loop: record state updates at each step.
//  A skid register behind the output keeps input flowing for one extra
//  result while m_axis stalls; s_axis_tready drops only when the input register and skid entry are both full.
//  rst_n clears all control state and sets base_address to 0x08000000.
// ----------------------------------------------------------------------------
module hex_record_data_extractor
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] addr, [38:32] index, [54:39] halfword
    output logic        m_axis_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data        // [31:0] base_address
);
    import hrde_pkg::*;

    // Configuration register, always writable
    logic [31:0] base_address_reg;

    // Input register stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;

    // Output register plus one skid entry
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;

    logic        in_xfer;
    logic        out_xfer;
    logic        advance;
    logic        res_valid;
    result_t     res;

    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;
    // The parser steps whenever a character is held and the skid entry is free to catch its result
    assign advance       = in_valid_reg && !skid_valid_reg;
    assign s_axis_tready = !in_valid_reg || !skid_valid_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {1'b0, out_reg.halfword, out_reg.word_index,
                            out_reg.record_address};

    hrde_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .char_in      (in_char_reg),
        .base_address (base_address_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    // Output queue: a new result goes to the output register if that slot is
    // free or draining this cycle, otherwise into the skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (advance && res_valid)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= BASE_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_address_reg <= cfg_data;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_char_reg <= s_axis_tdata;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while output slot is empty");

    a_full_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && skid_valid_reg |-> !s_axis_tready)
        else $error("input accepted while pipeline is full");

    a_skid_fills_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && advance && res_valid && out_valid_reg && !m_axis_tready
        |=> skid_valid_reg)
        else $error("result dropped during output stall");

endmodule

/* design/hrde_parser.sv */
// ----------------------------------------------------------------------------
// hrde_parser
// Record state tracker: consumes one character per step, holds the count,
// offset and partial halfword, and flags a result on every fourth data char.
// ----------------------------------------------------------------------------
module hrde_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_in,
    input  logic [31:0]         base_address,
    output logic                res_valid,
    output hrde_pkg::result_t   res
);
    import hrde_pkg::*;

    logic [9:0]  char_position_reg, char_position_next;
    logic        in_record_reg, in_record_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] load_offset_reg, load_offset_next;
    logic [11:0] nibble_accum_reg, nibble_accum_next;

    logic [3:0]  nib;
    logic [6:0]  pages;
    logic [9:0]  rel;
    logic [6:0]  idx;
    logic [7:0]  idx_plus;

    assign nib      = to_nibble(char_in);
    assign pages    = byte_count_reg[7:1];
    assign rel      = char_position_reg - POS_DATA;
    assign idx      = rel[8:2];
    assign idx_plus = {1'b0, idx} + 8'd1;

    always_comb
    begin
        char_position_next = char_position_reg;
        in_record_next     = in_record_reg;
        byte_count_next    = byte_count_reg;
        load_offset_next   = load_offset_reg;
        nibble_accum_next  = nibble_accum_reg;
        res_valid          = 1'b0;
        res.record_address = base_address | {16'd0, load_offset_reg};
        res.word_index     = idx;
        res.halfword       = {nibble_accum_reg[3:0], nib, nibble_accum_reg[11:4]};
        res.last           = (idx_plus >= {1'b0, pages});

        if (step)
        begin
            if (char_in == CHAR_COLON)
            begin
                in_record_next     = 1'b1;
                char_position_next = 10'd1;
                byte_count_next    = '0;
                load_offset_next   = '0;
                nibble_accum_next  = '0;
            end
            else if (in_record_reg)
            begin
                char_position_next = char_position_reg + 10'd1;
                if (char_position_reg <= POS_COUNT_END)
                    byte_count_next = {byte_count_reg[3:0], nib};
                else if (char_position_reg <= POS_OFFSET_END)
                    load_offset_next = {load_offset_reg[11:0], nib};
                else if (char_position_reg == POS_SKIP)
                    char_position_next = char_position_reg + 10'd1;
                else if (char_position_reg == POS_TYPE)
                begin
                    // only a data record with at least one halfword goes on
                    if (nib != TYPE_DATA || pages == 7'd0)
                        in_record_next = 1'b0;
                end
                else if (rel[1:0] != 2'b11)
                    nibble_accum_next = {nibble_accum_reg[7:0], nib};
                else
                begin
                    res_valid         = 1'b1;
                    nibble_accum_next = '0;
                    if (res.last)
                        in_record_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg <= '0;
            in_record_reg     <= 1'b0;
            byte_count_reg    <= '0;
            load_offset_reg   <= '0;
            nibble_accum_reg  <= '0;
        end
        else
        begin
            char_position_reg <= char_position_next;
            in_record_reg     <= in_record_next;
            byte_count_reg    <= byte_count_next;
            load_offset_reg   <= load_offset_next;
            nibble_accum_reg  <= nibble_accum_next;
        end
    end

    a_res_needs_step : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step && in_record_reg)
        else $error("result without an active record step");

    a_last_closes : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> !in_record_reg)
        else $error("record still open after its last halfword");

endmodule
